// ===== rtl/core/lvp_pkg.sv =====
// Shared types and constants for the longest valid parenthesis run block.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
package lvp_pkg;

  localparam int LEN_W       = 11;
  localparam int CHAR_W      = 8;
  localparam int DEF_MAX_LEN = 1024;

  localparam logic [CHAR_W-1:0] OPEN_BYTE = 8'h28;

  typedef struct packed {
    logic [LEN_W-1:0] best_length;
    logic [LEN_W-1:0] run_length;
    logic             final_result;
    logic             too_long;
  } result_t;

endpackage

// ===== rtl/core/lvp_in_if.sv =====
// Character channel: valid/ready handshake with one character per beat.
// Depends on lvp_pkg for field widths.
`timescale 1ns / 1ps
interface lvp_in_if import lvp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              first_char;
  logic              last_char;

  modport source (output valid, output char_byte, output first_char, output last_char,
                  input ready);
  modport sink (input valid, input char_byte, input first_char, input last_char,
                output ready);
endinterface

// ===== rtl/core/lvp_out_if.sv =====
// Result channel: valid/ready handshake with one result per beat.
// Depends on lvp_pkg for field widths.
`timescale 1ns / 1ps
interface lvp_out_if import lvp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] best_length;
  logic [LEN_W-1:0] run_length;
  logic             final_result;
  logic             too_long;

  modport source (output valid, output best_length, output run_length,
                  output final_result, output too_long, input ready);
  modport sink (input valid, input best_length, input run_length,
                input final_result, input too_long, output ready);
endinterface

// ===== rtl/core/lvp_stack.sv =====
// Index stack engine: top and next-below entries in registers, the rest in a
// synchronous RAM with a registered read. Depends on lvp_pkg.
`timescale 1ns / 1ps
module lvp_stack import lvp_pkg::*; #(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic [CHAR_W-1:0] char_byte,
  input  logic              first_char,
  input  logic              last_char,
  output result_t           res
);

  localparam int TW    = $clog2(MAX_LEN + 1);
  localparam int CW    = $clog2(MAX_LEN + 2);
  localparam int DEPTH = MAX_LEN + 1;

  localparam logic [CW-1:0] CNT_ZERO  = CW'(0);
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);
  localparam logic [CW-1:0] CNT_TWO   = CW'(2);
  localparam logic [CW-1:0] CNT_THREE = CW'(3);
  localparam logic [CW-1:0] CNT_FULL  = CW'(MAX_LEN + 1);
  localparam logic [TW-1:0] POS_LIMIT = TW'(MAX_LEN);

  logic [TW-1:0] mem [DEPTH];
  logic [TW-1:0] rdata;

  logic [CW-1:0] count, count_next, count_e, rd_full;
  logic [TW-1:0] top, top_next, top_e;
  logic [TW-1:0] below, below_next, below_e;
  logic          below_mem, below_mem_next;
  logic [TW-1:0] base, base_next, base_e;
  logic [TW-1:0] position, position_next, pos_e;
  logic [TW-1:0] best, best_next, best_e;
  logic          overflow, overflow_next, ovf_e;
  logic [TW-1:0] tag, run;
  logic          wr_en, rd_en;

  always_comb begin
    // a first mark restarts the string before this character is handled
    count_e = first_char ? CNT_ONE : count;
    top_e   = first_char ? '0 : top;
    base_e  = first_char ? '0 : base;
    pos_e   = first_char ? '0 : position;
    best_e  = first_char ? '0 : best;
    ovf_e   = first_char ? 1'b0 : overflow;
    below_e = below_mem ? rdata : below;
    tag     = pos_e + TW'(1);
    rd_full = count_e - CNT_THREE;

    count_next     = count_e;
    top_next       = top_e;
    below_next     = below_e;
    below_mem_next = 1'b0;
    base_next      = base_e;
    position_next  = pos_e;
    best_next      = best_e;
    overflow_next  = ovf_e;
    run            = '0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;

    if (pos_e >= POS_LIMIT) begin
      overflow_next = 1'b1;
    end else begin
      position_next = tag;
      if (char_byte == OPEN_BYTE) begin
        if (count_e < CNT_FULL) begin
          count_next = count_e + CNT_ONE;
          top_next   = tag;
          below_next = top_e;
          if (count_e == CNT_ZERO) begin
            base_next = tag;
          end else begin
            wr_en = 1'b1;
          end
        end
      end else if (count_e >= CNT_TWO) begin
        // pop: old below becomes top, fetch the entry under it
        count_next = count_e - CNT_ONE;
        top_next   = below_e;
        run        = (tag >= below_e) ? tag - below_e : '0;
        if (run > best_e) begin
          best_next = run;
        end
        if (count_e == CNT_THREE) begin
          below_next = base_e;
        end else if (count_e > CNT_THREE) begin
          rd_en          = 1'b1;
          below_mem_next = 1'b1;
        end
      end else begin
        // stack emptied: this position becomes the new base
        count_next = CNT_ONE;
        top_next   = tag;
        base_next  = tag;
      end
    end

    res.best_length  = LEN_W'(best_next);
    res.run_length   = LEN_W'(run);
    res.final_result = last_char;
    res.too_long     = overflow_next;
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      mem[count_e[TW-1:0]] <= tag;
    end
    if (acc && rd_en) begin
      rdata <= mem[rd_full[TW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      below <= below_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= CNT_ONE;
      top       <= '0;
      base      <= '0;
      below_mem <= 1'b0;
      position  <= '0;
      best      <= '0;
      overflow  <= 1'b0;
    end else if (acc) begin
      count     <= count_next;
      top       <= top_next;
      base      <= base_next;
      below_mem <= below_mem_next;
      position  <= position_next;
      best      <= best_next;
      overflow  <= overflow_next;
    end
  end

endmodule

// ===== rtl/core/lvp_skid.sv =====
// Two-entry output buffer: output register plus skid register, so the
// input side keeps taking beats while a result waits. Depends on lvp_pkg.
`timescale 1ns / 1ps
module lvp_skid import lvp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    ready,
  output logic    valid,
  input  logic    pop_ready,
  output result_t data
);

  result_t skid;
  logic    skid_valid;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop_ready || !valid) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready || !valid) begin
      data <= skid_valid ? skid : push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

// ===== rtl/core/longest_valid_paren_run_top.sv =====
// Top level of the longest valid parenthesis run block: stack engine plus
// output buffer. Depends on lvp_pkg, lvp_in_if, lvp_out_if, lvp_stack, lvp_skid.
//
//   channel   dir  beat
//   chars     in   char_byte[7:0], first_char, last_char
//   results   out  best_length[10:0], run_length[10:0], final_result, too_long
//
// One character per cycle while chars.ready is high; each result is registered
// in the output buffer before it appears on results. The stack top and next-below
// entry sit in registers, so consecutive pops never wait on the stack RAM's read.
// Synchronous active-high reset empties the output buffer and restores the
// base-only stack; no clearing pass is needed. chars.ready drops only when two
// results are held unread.
`timescale 1ns / 1ps
module longest_valid_paren_run_top import lvp_pkg::*; #(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input logic       clk,
  input logic       rst,
  lvp_in_if.sink    chars,
  lvp_out_if.source results
);

  logic    acc;
  result_t res, held;

  assign acc = chars.valid && chars.ready;

  lvp_stack #(
    .MAX_LEN(MAX_LEN)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .char_byte (chars.char_byte),
    .first_char(chars.first_char),
    .last_char (chars.last_char),
    .res       (res)
  );

  lvp_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (acc),
    .push_data(res),
    .ready    (chars.ready),
    .valid    (results.valid),
    .pop_ready(results.ready),
    .data     (held)
  );

  assign results.best_length  = held.best_length;
  assign results.run_length   = held.run_length;
  assign results.final_result = held.final_result;
  assign results.too_long     = held.too_long;

endmodule

// ===== dv/tb_longest_valid_paren_run_top.sv =====
// Self-checking bench for longest_valid_paren_run_top: directed and random strings,
// with a per-string bracket stack predictor that matches each result beat in order.
// Depends on lvp_pkg, lvp_in_if, lvp_out_if and the RTL under rtl/core.
`timescale 1ns / 1ps
module tb_longest_valid_paren_run_top;
  import lvp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 200;
  localparam logic [CHAR_W-1:0] CLOSE_BYTE = 8'h29;

  class paren_run_scoreboard;
    int unsigned open_tags [0:DEF_MAX_LEN];
    int unsigned depth;
    int unsigned char_pos;
    int unsigned best_run;
    bit          overflowed;
    result_t     expected_runs[$];
    int          mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    // Base entry zero stands for position minus one.
    function void restart();
      foreach (open_tags[i]) open_tags[i] = 0;
      depth = 1;
      char_pos = 0;
      best_run = 0;
      overflowed = 1'b0;
    endfunction

    function void push_tag(int unsigned tag);
      if (depth < DEF_MAX_LEN + 1) begin
        open_tags[depth] = tag;
        depth++;
      end
    endfunction

    function void note_char(logic [CHAR_W-1:0] ch, logic first, logic last);
      result_t     want;
      int unsigned tag;
      int unsigned run;
      run = 0;
      if (first) restart();
      if (char_pos >= DEF_MAX_LEN) begin
        overflowed = 1'b1;
      end else begin
        tag = char_pos + 1;
        if (ch == OPEN_BYTE) begin
          push_tag(tag);
        end else begin
          if (depth > 0) depth--;
          if (depth > 0) begin
            run = (tag >= open_tags[depth-1]) ? tag - open_tags[depth-1] : 0;
            if (run > best_run) best_run = run;
          end else begin
            push_tag(tag);
          end
        end
        char_pos++;
      end
      want.best_length  = best_run[LEN_W-1:0];
      want.run_length   = run[LEN_W-1:0];
      want.final_result = last;
      want.too_long     = overflowed;
      expected_runs.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_runs.size() == 0) begin
        report_mismatch("unexpected beat, best_length", int'(got.best_length), -1);
        return;
      end
      want = expected_runs.pop_front();
      if (got.best_length !== want.best_length)
        report_mismatch("best_length", int'(got.best_length), int'(want.best_length));
      if (got.run_length !== want.run_length)
        report_mismatch("run_length", int'(got.run_length), int'(want.run_length));
      if (got.final_result !== want.final_result)
        report_mismatch("final_result", int'(got.final_result), int'(want.final_result));
      if (got.too_long !== want.too_long)
        report_mismatch("too_long", int'(got.too_long), int'(want.too_long));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   stall_left = 0;
  int   random_items = 0;
  bit   hold_request = 1'b0;
  bit   no_gaps = 1'b0;

  paren_run_scoreboard sb = new();

  lvp_in_if  chars();
  lvp_out_if results();

  longest_valid_paren_run_top #(.MAX_LEN(DEF_MAX_LEN)) DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t seen;
    if (!rst && results.valid && results.ready) begin
      seen.best_length  = results.best_length;
      seen.run_length   = results.run_length;
      seen.final_result = results.final_result;
      seen.too_long     = results.too_long;
      sb.check_result(seen);
    end
  end

  // Result receiver: random stalls, quiet stretches, and one long hold on request.
  initial begin : result_receiver
    int r;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        results.ready <= 1'b0;
        stall_left--;
      end else if (cycle_count[9:8] == 2'd0) begin
        results.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          results.ready <= 1'b0;
          stall_left = (r < 10) ? $urandom_range(0, 2) : $urandom_range(8, 30);
        end else begin
          results.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_char(logic [CHAR_W-1:0] ch, logic first, logic last);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    repeat (gap) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid      <= 1'b1;
    chars.char_byte  <= ch;
    chars.first_char <= first;
    chars.last_char  <= last;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    sb.note_char(ch, first, last);
  endtask

  task automatic wait_drained();
    chars.valid <= 1'b0;
    while (sb.expected_runs.size() != 0) @(posedge clk);
  endtask

  // Mostly bracket strings with random content; some pure noise and broken marks.
  task automatic send_random_string();
    int kind;
    int len;
    int open_cnt;
    logic [CHAR_W-1:0] ch;
    logic first;
    logic last;
    kind = $urandom_range(0, 9);
    len = $urandom_range(1, 40);
    open_cnt = 0;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if (kind == 7) begin
        ch = 8'($urandom_range(0, 255));
      end else if (kind == 9) begin
        ch = (i < len / 2) ? OPEN_BYTE : CLOSE_BYTE;
      end else if ($urandom_range(0, 9) == 0) begin
        ch = 8'($urandom_range(0, 255));
      end else if (open_cnt == 0 || (open_cnt < len - i - 1 && $urandom_range(0, 1))) begin
        ch = OPEN_BYTE;
      end else begin
        ch = CLOSE_BYTE;
      end
      if (ch == OPEN_BYTE) open_cnt++;
      else if (open_cnt > 0) open_cnt--;
      first = (i == 0);
      last = (i == len - 1);
      if (kind == 8) begin
        first = (i == 0) && $urandom_range(0, 1);
        last = ($urandom_range(0, 3) == 0);
      end
      send_char(ch, first, last);
      random_items++;
    end
  endtask

  // Past MAX_LEN characters: nested form reaches the widest best_length.
  task automatic send_long_string();
    int len;
    logic [CHAR_W-1:0] ch;
    len = DEF_MAX_LEN + 2;
    no_gaps = 1'b0;
    for (int i = 0; i < len; i++) begin
      ch = (i < DEF_MAX_LEN / 2) ? OPEN_BYTE : CLOSE_BYTE;
      send_char(ch, i == 0, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int n;
    chars.valid      <= 1'b0;
    chars.char_byte  <= '0;
    chars.first_char <= 1'b0;
    chars.last_char  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // No first mark after reset: continue from the reset state.
    send_char(OPEN_BYTE, 1'b0, 1'b0);
    send_char(CLOSE_BYTE, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(OPEN_BYTE, 1'b0, 1'b0);
    send_char(OPEN_BYTE, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(CLOSE_BYTE, 1'b0, 1'b1);
    // Deep stack, then a restart in the middle of it.
    send_char(OPEN_BYTE, 1'b1, 1'b0);
    send_char(OPEN_BYTE, 1'b0, 1'b0);
    send_char(OPEN_BYTE, 1'b0, 1'b0);
    send_char(OPEN_BYTE, 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b1);
    // Single-character strings.
    send_char(OPEN_BYTE, 1'b1, 1'b1);
    send_char(8'hFF, 1'b1, 1'b1);
    // Closers only, each leaving the stack empty.
    send_char(8'h80, 1'b1, 1'b0);
    send_char(8'h7F, 1'b0, 1'b0);
    send_char(8'hD7, 1'b0, 1'b0);
    send_char(8'h27, 1'b0, 1'b0);
    send_char(CLOSE_BYTE, 1'b0, 1'b1);
    // Any non-open byte closes.
    send_char(OPEN_BYTE, 1'b1, 1'b0);
    send_char(OPEN_BYTE, 1'b0, 1'b0);
    send_char(8'hA5, 1'b0, 1'b0);
    send_char(8'h5A, 1'b0, 1'b1);
    wait_drained();

    n = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (n == 1) hold_request = 1'b1;
      if (n == 3) send_long_string();
      if (n == 6) wait_drained();
      send_random_string();
      n++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_runs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
